// ===== design/mpsa_pkg.sv =====
`default_nettype none
package mpsa_pkg;

  localparam int TOTAL_BITS_DEF   = 256;
  localparam int WORD_BITS_DEF    = 64;
  localparam int MAX_PATTERNS_DEF = 32;
  localparam int ALPHABET_MAX_DEF = 8;

  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int POS_W     = 32;
  localparam int ID_W      = 6;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W    = 4;

  localparam logic [ID_W-1:0] NO_ID_CODE = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_LETTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic found;
    logic rest_empty;
  } pick_stat_t;

endpackage
`default_nettype wire

// ===== design/mpsa_if.sv =====
`default_nettype none
interface mpsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpsa_pkg::OP_W-1:0]    operation;
  logic [mpsa_pkg::SYM_W-1:0]   symbol;
  logic                         pattern_end;
  logic [mpsa_pkg::POS_W-1:0]   start_position;
  logic                         keep_state;

  modport source (output valid, operation, symbol, pattern_end, start_position, keep_state,
                  input ready);
  modport sink (input valid, operation, symbol, pattern_end, start_position, keep_state,
                output ready);
endinterface

interface mpsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpsa_pkg::POS_W-1:0]   text_position;
  logic [mpsa_pkg::ID_W-1:0]    match_id;
  logic                         last_match;

  modport source (output valid, text_position, match_id, last_match, input ready);
  modport sink (input valid, text_position, match_id, last_match, output ready);
endinterface
`default_nettype wire

// ===== design/mpsa_letter_lookup.sv =====
`default_nettype none
module mpsa_letter_lookup #(
  parameter int ALPHABET_MAX = mpsa_pkg::ALPHABET_MAX_DEF,
  parameter int LW           = (ALPHABET_MAX > 1) ? $clog2(ALPHABET_MAX) : 1
) (
  input  wire logic [mpsa_pkg::CFG_W-1:0]  letters,
  input  wire logic [mpsa_pkg::SIZE_W-1:0] size,
  input  wire logic [mpsa_pkg::SYM_W-1:0]  sym,
  output logic                             found,
  output logic [LW-1:0]                    index
);
  import mpsa_pkg::*;

  logic [SIZE_W-1:0] n_used;

  always_comb begin
    n_used = (size > SIZE_W'(ALPHABET_MAX)) ? SIZE_W'(ALPHABET_MAX) : size;
    found  = 1'b0;
    index  = '0;
    // later letters override earlier duplicates
    for (int i = 0; i < ALPHABET_MAX; i++) begin
      if ((SIZE_W'(i) < n_used) && (letters[8*i +: 8] == sym)) begin
        found = 1'b1;
        index = LW'(i);
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/mpsa_word_step.sv =====
`default_nettype none
module mpsa_word_step #(
  parameter int WORD_BITS = mpsa_pkg::WORD_BITS_DEF
) (
  input  wire logic [WORD_BITS-1:0] old_bits,
  input  wire logic                 carry_in,
  input  wire logic [WORD_BITS-1:0] start_bits,
  input  wire logic [WORD_BITS-1:0] mask_bits,
  input  wire logic [WORD_BITS-1:0] end_bits,
  output logic [WORD_BITS-1:0]      new_bits,
  output logic [WORD_BITS-1:0]      hit_bits,
  output logic                      carry_out
);
  always_comb begin
    new_bits  = ({old_bits[WORD_BITS-2:0], carry_in} | start_bits) & mask_bits;
    hit_bits  = new_bits & end_bits;
    carry_out = old_bits[WORD_BITS-1];
  end
endmodule
`default_nettype wire

// ===== design/mpsa_hit_pick.sv =====
`default_nettype none
module mpsa_hit_pick #(
  parameter int WORD_BITS = mpsa_pkg::WORD_BITS_DEF,
  parameter int CW        = $clog2(WORD_BITS + 1)
) (
  input  wire logic [WORD_BITS-1:0] hits,
  input  wire logic [WORD_BITS-1:0] ends,
  output logic [CW-1:0]             below_cnt,
  output logic [CW-1:0]             word_cnt,
  output logic [WORD_BITS-1:0]      rest,
  output mpsa_pkg::pick_stat_t      stat
);
  import mpsa_pkg::*;

  logic [WORD_BITS-1:0] low_bit;

  always_comb begin
    // isolate the lowest hit; its rank is the count of end bits below it
    low_bit         = hits & (~hits + WORD_BITS'(1));
    rest            = hits & ~low_bit;
    below_cnt       = CW'($countones(ends & (low_bit - WORD_BITS'(1))));
    word_cnt        = CW'($countones(ends));
    stat.found      = |hits;
    stat.rest_empty = ~|rest;
  end
endmodule
`default_nettype wire

// ===== design/multi_pattern_shift_and_matcher_top.sv =====
`default_nettype none
// Multi-pattern Shift-And matcher.
// in_if (valid/ready) takes requests: load pattern symbol, start search,
// search text symbol, clear patterns. out_if (valid/ready) returns one
// request per pattern that ends at a text symbol: position, pattern id and
// a flag on the last one for that symbol. cfg_we/cfg_index/cfg_wdata write
// the alphabet letters, alphabet size and id reporting; write only when idle.
// Load, start and clear complete when accepted, as does a search symbol that
// is not a letter or that finds the store empty. Any other search symbol is
// accepted, then updates the match words through the one shared word unit
// (one word per cycle with carry), then scans the words: it steps past each
// word before the one holding the final result, and for each result picks
// it, then holds it until taken.
// in_if.ready is high only while idle. A stalled receiver holds the result
// in its output register and the block waits; nothing is dropped.
// Synchronous reset empties the pattern store, clears match bits and the
// position, sets the alphabet size to zero and enables id reporting.
module multi_pattern_shift_and_matcher_top #(
  parameter int TOTAL_BITS   = mpsa_pkg::TOTAL_BITS_DEF,
  parameter int WORD_BITS    = mpsa_pkg::WORD_BITS_DEF,
  parameter int MAX_PATTERNS = mpsa_pkg::MAX_PATTERNS_DEF,
  parameter int ALPHABET_MAX = mpsa_pkg::ALPHABET_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mpsa_in_if.sink                             in_if,
  mpsa_out_if.source                          out_if,
  input  wire logic                           cfg_we,
  input  wire logic [mpsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mpsa_pkg::CFG_W-1:0]     cfg_wdata
);
  import mpsa_pkg::*;

  localparam int NWORDS = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIDX   = $clog2(WORD_BITS);
  localparam int LW     = (ALPHABET_MAX > 1) ? $clog2(ALPHABET_MAX) : 1;
  localparam int TLW    = $clog2(TOTAL_BITS + 1);
  localparam int PCW    = $clog2(MAX_PATTERNS + 1);
  localparam int CW     = $clog2(WORD_BITS + 1);

  // configuration
  logic [CFG_W-1:0]  letters_r;
  logic [SIZE_W-1:0] size_r;
  logic              report_r;

  // pattern store and search state
  logic [WORD_BITS-1:0] mb_r [NWORDS];
  logic [WORD_BITS-1:0] sb_r [NWORDS];
  logic [WORD_BITS-1:0] eb_r [NWORDS];
  logic [WORD_BITS-1:0] lm_r [NWORDS][ALPHABET_MAX];
  logic [WORD_BITS-1:0] hits_r [NWORDS];
  logic [NWORDS-1:0]    any_r;
  logic [TLW-1:0]       tl_r;
  logic [WIDX-1:0]      wsel_r;
  logic [BIDX-1:0]      bsel_r;
  logic [PCW-1:0]       pc_r;
  logic                 open_r;
  logic [POS_W-1:0]     pos_r;

  logic [WIDX-1:0]      w_r;
  logic                 carry_r;
  logic [LW-1:0]        li_r;
  logic [PCW-1:0]       rb_r;

  logic [POS_W-1:0]     opos_r;
  logic [ID_W-1:0]      oid_r;
  logic                 olast_r;

  state_t state_r, state_nxt;

  logic                 in_fire, out_fire, last_word, later_any, store_ok;
  logic                 lk_found;
  logic [LW-1:0]        lk_index;
  logic [WORD_BITS-1:0] ws_new, ws_hits;
  logic                 ws_carry;
  logic [CW-1:0]        pk_below, pk_word;
  logic [WORD_BITS-1:0] pk_rest;
  pick_stat_t           pk_stat;
  op_t                  op;

  assign op        = op_t'(in_if.operation);
  assign in_fire   = in_if.valid && in_if.ready;
  assign out_fire  = out_if.valid && out_if.ready;
  assign last_word = (w_r == WIDX'(NWORDS - 1));
  assign store_ok  = (tl_r != TLW'(TOTAL_BITS)) && (open_r || (pc_r != PCW'(MAX_PATTERNS)));

  always_comb begin
    later_any = 1'b0;
    for (int i = 0; i < NWORDS; i++) begin
      if (WIDX'(i) > w_r) later_any = later_any | any_r[i];
    end
  end

  mpsa_letter_lookup #(.ALPHABET_MAX(ALPHABET_MAX), .LW(LW)) u_lookup (
    .letters(letters_r),
    .size   (size_r),
    .sym    (in_if.symbol),
    .found  (lk_found),
    .index  (lk_index)
  );

  mpsa_word_step #(.WORD_BITS(WORD_BITS)) u_step (
    .old_bits  (mb_r[w_r]),
    .carry_in  (carry_r),
    .start_bits(sb_r[w_r]),
    .mask_bits (lm_r[w_r][li_r]),
    .end_bits  (eb_r[w_r]),
    .new_bits  (ws_new),
    .hit_bits  (ws_hits),
    .carry_out (ws_carry)
  );

  mpsa_hit_pick #(.WORD_BITS(WORD_BITS), .CW(CW)) u_pick (
    .hits     (hits_r[w_r]),
    .ends     (eb_r[w_r]),
    .below_cnt(pk_below),
    .word_cnt (pk_word),
    .rest     (pk_rest),
    .stat     (pk_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letters_r <= '0;
      size_r    <= '0;
      report_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LETTERS: letters_r <= cfg_wdata;
        CFG_SIZE:    size_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_REPORT:  report_r  <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && op == OP_SEARCH && tl_r != '0 && lk_found) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (last_word) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (pk_stat.found) state_nxt = ST_OUT;
        else if (last_word) state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (out_fire) state_nxt = olast_r ? ST_IDLE : ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_if.ready          = (state_r == ST_IDLE);
    out_if.valid         = (state_r == ST_OUT);
    out_if.text_position = opos_r;
    out_if.match_id      = oid_r;
    out_if.last_match    = olast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NWORDS; j++) begin
        mb_r[j] <= '0;
        sb_r[j] <= '0;
        eb_r[j] <= '0;
        for (int a = 0; a < ALPHABET_MAX; a++) lm_r[j][a] <= '0;
      end
      tl_r    <= '0;
      wsel_r  <= '0;
      bsel_r  <= '0;
      pc_r    <= '0;
      open_r  <= 1'b0;
      pos_r   <= '0;
      w_r     <= '0;
      carry_r <= 1'b0;
      rb_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (op)
              OP_LOAD: begin
                if (store_ok) begin
                  if (!open_r) begin
                    sb_r[wsel_r][bsel_r] <= 1'b1;
                    open_r <= 1'b1;
                  end
                  if (lk_found) lm_r[wsel_r][lk_index][bsel_r] <= 1'b1;
                  if (in_if.pattern_end) begin
                    eb_r[wsel_r][bsel_r] <= 1'b1;
                    pc_r   <= pc_r + PCW'(1);
                    open_r <= 1'b0;
                  end
                  tl_r <= tl_r + TLW'(1);
                  if (bsel_r == BIDX'(WORD_BITS - 1)) begin
                    bsel_r <= '0;
                    wsel_r <= wsel_r + WIDX'(1);
                  end else begin
                    bsel_r <= bsel_r + BIDX'(1);
                  end
                end
              end
              OP_START: begin
                pos_r <= in_if.start_position;
                if (!in_if.keep_state) begin
                  for (int j = 0; j < NWORDS; j++) mb_r[j] <= '0;
                end
              end
              OP_SEARCH: begin
                if (tl_r != '0) begin
                  if (lk_found) begin
                    li_r    <= lk_index;
                    w_r     <= '0;
                    carry_r <= 1'b0;
                  end else begin
                    // unknown letter: drop all partial matches
                    for (int j = 0; j < NWORDS; j++) mb_r[j] <= '0;
                    pos_r <= pos_r + POS_W'(1);
                  end
                end
              end
              default: begin
                for (int j = 0; j < NWORDS; j++) begin
                  mb_r[j] <= '0;
                  sb_r[j] <= '0;
                  eb_r[j] <= '0;
                  for (int a = 0; a < ALPHABET_MAX; a++) lm_r[j][a] <= '0;
                end
                tl_r   <= '0;
                wsel_r <= '0;
                bsel_r <= '0;
                pc_r   <= '0;
                open_r <= 1'b0;
              end
            endcase
          end
        end
        ST_UPDATE: begin
          mb_r[w_r]   <= ws_new;
          hits_r[w_r] <= ws_hits;
          any_r[w_r]  <= |ws_hits;
          carry_r     <= ws_carry;
          w_r         <= last_word ? '0 : w_r + WIDX'(1);
          rb_r        <= '0;
        end
        ST_SCAN: begin
          if (pk_stat.found) begin
            opos_r      <= pos_r;
            oid_r       <= report_r ? ID_W'(rb_r + PCW'(pk_below)) : NO_ID_CODE;
            olast_r     <= pk_stat.rest_empty && !later_any;
            hits_r[w_r] <= pk_rest;
            any_r[w_r]  <= !pk_stat.rest_empty;
          end else if (last_word) begin
            pos_r <= pos_r + POS_W'(1);
          end else begin
            rb_r <= rb_r + PCW'(pk_word);
            w_r  <= w_r + WIDX'(1);
          end
        end
        ST_OUT: begin
          if (out_fire && olast_r) pos_r <= pos_r + POS_W'(1);
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input ready while a result is pending");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tl_r <= TLW'(TOTAL_BITS)) && (pc_r <= PCW'(MAX_PATTERNS)))
    else $error("pattern store over capacity");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_if.last_match) |=> in_if.ready)
    else $error("not idle after final result");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.match_id)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
